FILE: hw/rtl/vsf_pkg.sv
// Shared types and constants for the variation selector filter.
// No dependencies; used by vsf_cell and variation_selector_filter.
package vsf_pkg;

  localparam int CpW      = 21;
  localparam int IdxW     = 9;
  localparam int DefDepth = 512;

  localparam logic [CpW-1:0] VsLoA = 21'h00FE00;
  localparam logic [CpW-1:0] VsHiA = 21'h00FE0F;
  localparam logic [CpW-1:0] VsLoB = 21'h0E0100;
  localparam logic [CpW-1:0] VsHiB = 21'h0E01EF;

  typedef enum logic {
    ACT_FILTER = 1'b0,
    ACT_WRITE  = 1'b1
  } action_t;

  // Item travelling down the cell row.
  // A query carries the code point in a and the preceding code point in b.
  // A table write carries the selector in a and the base in b.
  typedef struct packed {
    logic            valid;
    action_t         act;
    logic            chk;     // query needs a table hit to be kept
    logic            hit;     // a cell already matched
    logic            wvalid;  // entry valid flag for writes
    logic [CpW-1:0]  a;
    logic [CpW-1:0]  b;
    logic [IdxW-1:0] idx;
  } token_t;

  function automatic logic is_selector(input logic [CpW-1:0] cp);
    is_selector = ((cp >= VsLoA) && (cp <= VsHiA)) || ((cp >= VsLoB) && (cp <= VsHiB));
  endfunction

endpackage

FILE: hw/rtl/vsf_cell.sv
// One cell of the allowed-pair row: holds one table entry and one item slot.
// Depends on vsf_pkg.
module vsf_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            advance,
  input  vsf_pkg::token_t tok_in,
  output vsf_pkg::token_t tok_out
);
  import vsf_pkg::*;

  logic           ent_valid_r;
  logic [CpW-1:0] ent_sel_r;
  logic [CpW-1:0] ent_base_r;
  token_t         tok_r;
  token_t         tok_nxt;
  logic           wr_here;

  assign wr_here = tok_in.valid && (tok_in.act == ACT_WRITE) &&
                   (32'(tok_in.idx) == CELL_INDEX);

  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.valid && (tok_in.act == ACT_FILTER) && ent_valid_r &&
        (ent_sel_r == tok_in.a) && (ent_base_r == tok_in.b)) begin
      tok_nxt.hit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= 1'b0;
      tok_r.valid <= 1'b0;
    end else if (advance) begin
      tok_r <= tok_nxt;
      if (wr_here) begin
        ent_valid_r <= tok_in.wvalid;
        ent_sel_r   <= tok_in.a;
        ent_base_r  <= tok_in.b;
      end
    end
  end

  assign tok_out = tok_r;

endmodule

FILE: hw/rtl/variation_selector_filter.sv
// Variation selector filter: top level with input history, cell row and output register.
// Depends on vsf_pkg and vsf_cell.

// Items enter at one per cycle while the row is not stalled and travel down a row of
// TABLE_DEPTH cells, moving one cell each time the row advances; each cell holds one
// allowed-pair entry. A code point passes every cell and then the output register, and a
// sustained rate of one item per cycle is held as long as out_tready stays high. A
// stall on the output freezes the whole row. Table writes travel the same row, so a
// write is seen by every query taken after it and by none taken before. The table is
// invalid right after reset, with no clearing pass. Writes to a slot at or beyond
// TABLE_DEPTH are ignored and give no output; a dropped code point gives no output.
module variation_selector_filter #(
  parameter int TABLE_DEPTH = vsf_pkg::DefDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [20:0] code_point, [29:21] entry_index, [50:30] entry_selector,
  // [71:51] entry_base, [72] entry_valid, [79:73] zero
  input  logic [79:0] in_tdata,
  // [0] action, [1] first_of_text
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [20:0] kept_code_point, [23:21] zero
  output logic [23:0] out_tdata
);
  import vsf_pkg::*;

  logic           advance;
  logic           in_fire;
  logic [CpW-1:0] in_cp;
  logic           in_first;
  action_t        in_act;
  logic [CpW-1:0] prev_cp_r;
  logic           prev_valid_r;
  token_t         head;
  token_t         head_q;
  token_t         chain [TABLE_DEPTH+1];
  token_t         tail;
  logic           tail_keep;
  logic           out_valid_r;
  logic           out_valid_nxt;
  logic [CpW-1:0] out_cp_r;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = advance;
  assign in_fire   = in_tvalid && in_tready;
  assign in_cp     = in_tdata[20:0];
  assign in_first  = in_tuser[1];
  assign in_act    = action_t'(in_tuser[0]);

  always_comb begin
    head        = '0;
    head.valid  = in_tvalid;
    head.act    = in_act;
    head.idx    = in_tdata[29:21];
    if (in_act == ACT_WRITE) begin
      head.a      = in_tdata[50:30];
      head.b      = in_tdata[71:51];
      head.wvalid = in_tdata[72];
    end else begin
      head.a   = in_cp;
      head.b   = prev_cp_r;
      head.chk = is_selector(in_cp);
      // selectors at a text start or with no history can never be kept
      head.valid = in_tvalid;
    end
  end

  // Selector with no usable predecessor: force a drop by marking it so that a hit can't keep it.
  always_comb begin
    head_q = head;
    if ((in_act == ACT_FILTER) && head.chk && (in_first || !prev_valid_r)) begin
      head_q.valid = in_tvalid;
      head_q.hit   = 1'b0;
      head_q.wvalid = 1'b1;  // marks a forced drop for queries
    end
  end

  assign chain[0] = head_q;

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    vsf_cell #(
      .CELL_INDEX(k)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .advance(advance),
      .tok_in (chain[k]),
      .tok_out(chain[k+1])
    );
  end

  assign tail      = chain[TABLE_DEPTH];
  // for queries, wvalid set means the selector had no predecessor
  assign tail_keep = !tail.chk || (tail.hit && !tail.wvalid);
  assign out_valid_nxt = tail.valid && (tail.act == ACT_FILTER) && tail_keep;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_valid_r <= 1'b0;
      prev_cp_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_fire && (in_act == ACT_FILTER)) begin
        prev_valid_r <= 1'b1;
        prev_cp_r    <= in_cp;
      end
      if (advance) begin
        out_valid_r <= out_valid_nxt;
        out_cp_r    <= tail.a;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_cp_r};

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_history_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    prev_valid_r |=> prev_valid_r)
    else $error("filter history lost");

  a_out_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(tail.valid && (tail.act == ACT_FILTER)))
    else $error("output item not caused by a query");

  a_kept_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance && out_valid_nxt |=> out_tvalid && (out_tdata[20:0] == $past(tail.a)))
    else $error("kept item lost at output register");

endmodule

FILE: test/tb_variation_selector_filter.sv
`timescale 1ns / 1ps
// Self-checking testbench for variation_selector_filter: streams code points and table writes,
// predicts the kept code points and compares them with the output stream. Depends on vsf_pkg.
module tb_variation_selector_filter;
  import vsf_pkg::*;

  localparam int Depth       = DefDepth;
  localparam int NumItems    = 550;
  localparam int QuietTail   = 80;
  localparam int DrainCycles = Depth + 64;
  localparam int Limit       = 200000;

  typedef struct {
    action_t         act;
    logic [CpW-1:0]  cp;
    logic            first;
    logic [IdxW-1:0] idx;
    logic [CpW-1:0]  sel;
    logic [CpW-1:0]  base;
    logic            wvalid;
  } cp_item_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;

  // expected output and the predictor's own copy of the state
  cp_item_t       pending_q[$];
  logic [CpW-1:0] kept_q[$];
  logic           tbl_valid [0:Depth-1];
  logic [CpW-1:0] tbl_sel   [0:Depth-1];
  logic [CpW-1:0] tbl_base  [0:Depth-1];
  logic [CpW-1:0] hist_cp;
  logic           hist_valid;

  cp_item_t cur_item;
  logic     in_fire;
  logic     in_busy;
  logic     quiet;
  logic     pause_armed;
  int       send_gap;
  int       recv_gap;
  int       sent_cnt;
  int       accepted_cnt;
  int       total_items;
  int       pause_at;
  int       cycle_cnt;
  int       err_cnt;
  int       checked_cnt;
  int       n_writes;
  int       n_codes;
  int       n_sel_kept;
  int       n_sel_dropped;

  logic [CpW-1:0] pool_sel  [0:15];
  logic [CpW-1:0] pool_base [0:15];

  variation_selector_filter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic in_vs_range(logic [CpW-1:0] cp);
    return (cp >= VsLoA && cp <= VsHiA) || (cp >= VsLoB && cp <= VsHiB);
  endfunction

  function automatic logic [CpW-1:0] rand_vs();
    if ($urandom_range(0, 1) == 0) return CpW'(VsLoA + $urandom_range(0, 15));
    return CpW'(VsLoB + $urandom_range(0, 239));
  endfunction

  // unused fields carry random junk; the block must ignore them
  task automatic add_cp(logic [CpW-1:0] cp, logic first);
    cp_item_t it;
    it.act    = ACT_FILTER;
    it.cp     = cp;
    it.first  = first;
    it.idx    = IdxW'($urandom_range(0, 511));
    it.sel    = CpW'($urandom);
    it.base   = CpW'($urandom);
    it.wvalid = 1'($urandom_range(0, 1));
    pending_q = {pending_q, it};
  endtask

  task automatic add_write(logic [IdxW-1:0] idx, logic [CpW-1:0] sel, logic [CpW-1:0] base,
                           logic v);
    cp_item_t it;
    it.act    = ACT_WRITE;
    it.cp     = CpW'($urandom);
    it.first  = 1'($urandom_range(0, 1));
    it.idx    = idx;
    it.sel    = sel;
    it.base   = base;
    it.wvalid = v;
    pending_q = {pending_q, it};
  endtask

  function automatic void predict_kept(cp_item_t it);
    logic hit;
    if (it.act == ACT_WRITE) begin
      n_writes++;
      if (it.idx < Depth) begin
        tbl_valid[it.idx] = it.wvalid;
        tbl_sel[it.idx]   = it.sel;
        tbl_base[it.idx]  = it.base;
      end
    end else begin
      n_codes++;
      hit = 1'b1;
      if (in_vs_range(it.cp)) begin
        hit = 1'b0;
        if (!it.first && hist_valid) begin
          for (int k = 0; k < Depth; k++) begin
            if (tbl_valid[k] && tbl_sel[k] == it.cp && tbl_base[k] == hist_cp) hit = 1'b1;
          end
        end
        if (hit) n_sel_kept++;
        else n_sel_dropped++;
      end
      if (hit) kept_q = {kept_q, it.cp};
      hist_cp    = it.cp;
      hist_valid = 1'b1;
    end
  endfunction

  task automatic log_error(string what, logic [CpW-1:0] exp_cp, logic [CpW-1:0] got_cp);
    err_cnt++;
    if (err_cnt <= 10)
      $display("ERROR cycle %0d: %s expected %06h got %06h", cycle_cnt, what, exp_cp, got_cp);
  endtask

  task automatic build_directed();
    add_cp(VsLoA, 1'b0);                       // selector with no history: dropped
    add_write(9'd0, VsHiA, 21'h000041, 1'b1);
    add_write(9'd511, VsHiB, 21'h1FFFFF, 1'b1);
    add_write(9'd5, VsLoB, 21'h10FFFF, 1'b1);
    add_write(9'd6, VsHiA, 21'h000041, 1'b1);  // same pair twice
    add_cp(21'h000041, 1'b1);
    add_cp(VsHiA, 1'b0);
    add_cp(21'h000041, 1'b0);
    add_cp(VsHiA, 1'b1);                       // starts a text: dropped
    add_cp(21'h1FFFFF, 1'b0);                  // above U+10FFFF passes, then acts as base
    add_cp(VsHiB, 1'b0);
    add_cp(21'h10FFFF, 1'b1);
    add_cp(VsLoB, 1'b0);
    add_cp(21'h000000, 1'b0);
    add_cp(VsLoA, 1'b0);                       // no pair: dropped
    add_write(9'd0, VsHiA, 21'h000041, 1'b0);
    add_cp(21'h000041, 1'b0);
    add_cp(VsHiA, 1'b0);                       // duplicate slot still holds it
    add_write(9'd6, VsHiA, 21'h000041, 1'b0);
    add_cp(21'h000041, 1'b0);
    add_cp(VsHiA, 1'b0);
    add_cp(CpW'(VsLoA - 1), 1'b0);             // just outside both ranges
    add_cp(CpW'(VsHiA + 1), 1'b0);
    add_cp(CpW'(VsLoB - 1), 1'b1);
    add_cp(CpW'(VsHiB + 1), 1'b0);
  endtask

  task automatic build_random();
    int r;
    int k;
    for (int i = 0; i < 16; i++) begin
      pool_sel[i] = rand_vs();
      case ($urandom_range(0, 3))
        0: pool_base[i] = CpW'($urandom);
        1: pool_base[i] = rand_vs();
        default: pool_base[i] = CpW'($urandom_range(32, 16'hFFFF));
      endcase
      add_write(IdxW'(32 + i), pool_sel[i], pool_base[i], 1'b1);
    end
    while (pending_q.size() < NumItems) begin
      r = $urandom_range(0, 99);
      k = $urandom_range(0, 15);
      if (r < 12) begin
        if ($urandom_range(0, 4) == 0)
          add_write(IdxW'($urandom_range(0, 511)), CpW'($urandom), CpW'($urandom),
                    1'($urandom_range(0, 1)));
        else
          add_write(IdxW'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 511)
                                                       : $urandom_range(0, 63)),
                    pool_sel[k], pool_base[k], $urandom_range(0, 4) != 0);
      end else if (r < 75) begin
        add_cp(pool_base[k], $urandom_range(0, 5) == 0);
        add_cp(pool_sel[k], $urandom_range(0, 9) == 0);
      end else if (r < 88) begin
        add_cp(rand_vs(), $urandom_range(0, 7) == 0);
      end else begin
        add_cp(CpW'($urandom), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_fire) in_busy = 1'b0;
      if (!in_busy) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pause_armed && sent_cnt == pause_at) begin
          // hold the stream until every kept code point so far has come out
          if (kept_q.size() == 0) pause_armed = 1'b0;
        end else if (pending_q.size() > 0) begin
          if (!quiet && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(0, 11);
          end else begin
            cur_item = pending_q.pop_front();
            in_tdata <= {7'b0, cur_item.wvalid, cur_item.base, cur_item.sel, cur_item.idx,
                         cur_item.cp};
            in_tuser <= {cur_item.first, cur_item.act};
            in_busy = 1'b1;
            sent_cnt++;
          end
        end
      end
      in_tvalid <= in_busy;
    end
  end

  // output back-pressure
  always @(negedge clk) begin
    if (recv_gap > 0) begin
      recv_gap--;
      out_tready <= 1'b0;
    end else if (rst_n && !quiet && $urandom_range(0, 9) == 0) begin
      recv_gap = $urandom_range(0, 11);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // monitor: predict on accept, check on output
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > Limit) begin
      $display("Timeout after %0d cycles, %0d items accepted", cycle_cnt, accepted_cnt);
      $display("FAILURE");
      $finish;
    end else begin
      in_fire = rst_n && in_tvalid && in_tready;
      if (in_fire) begin
        predict_kept(cur_item);
        accepted_cnt++;
        quiet = (accepted_cnt + QuietTail >= total_items);
      end
      if (rst_n && out_tvalid && out_tready) begin
        checked_cnt++;
        if (kept_q.size() == 0) log_error("unexpected output", '0, out_tdata[CpW-1:0]);
        else if (kept_q[0] != out_tdata[CpW-1:0])
          log_error("kept_code_point", kept_q.pop_front(), out_tdata[CpW-1:0]);
        else void'(kept_q.pop_front());
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    out_tready  = 1'b0;
    in_fire     = 1'b0;
    in_busy     = 1'b0;
    quiet       = 1'b0;
    pause_armed = 1'b1;
    send_gap = 0; recv_gap = 0; sent_cnt = 0; accepted_cnt = 0;
    cycle_cnt = 0; err_cnt = 0; checked_cnt = 0;
    n_writes = 0; n_codes = 0; n_sel_kept = 0; n_sel_dropped = 0;
    hist_cp    = '0;
    hist_valid = 1'b0;
    for (int k = 0; k < Depth; k++) begin
      tbl_valid[k] = 1'b0;
      tbl_sel[k]   = '0;
      tbl_base[k]  = '0;
    end
    build_directed();
    build_random();
    total_items = pending_q.size();
    pause_at    = total_items / 2;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    while (accepted_cnt < total_items || kept_q.size() != 0) @(posedge clk);
    // dropped items may still be in the cell row
    repeat (DrainCycles) @(posedge clk);

    $display("Run covered %0d table writes and %0d code points; %0d selectors kept, %0d dropped.",
             n_writes, n_codes, n_sel_kept, n_sel_dropped);
    $display("%0d outputs checked, %0d errors, %0d cycles.", checked_cnt, err_cnt, cycle_cnt);
    if (err_cnt == 0 && kept_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
